FILE: rtl/core/dual_pool_page_bitmap_allocator_core_macros.svh
// assertion macros shared by the page allocator core files
`ifndef DUAL_POOL_PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define DUAL_POOL_PAGE_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DPBA_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DPBA_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: rtl/core/dpba_pkg.sv
// shared types, codes and helpers for the dual pool page allocator
package dpba_pkg;

	// bitmap storage word
	localparam int WORD_W = 32;
	localparam int BIT_W  = 5;
	typedef logic [WORD_W-1:0] word_t;

	// fixed field widths
	localparam int MODE_W     = 3;
	localparam int LPAGE_W    = 6;
	localparam int DPAGE_W    = 8;
	localparam int RPAGE_W    = 8;
	localparam int LCNT_OUT_W = 7;
	localparam int DCNT_OUT_W = 9;
	localparam int XFER_W     = 32;

	// request modes
	localparam logic [MODE_W-1:0] MODE_ALLOC_LOCAL  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC_DISK   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FREE_LOCAL   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FREE_DISK    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SWAP         = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MOVE_TO_DISK = 3'd5;
	localparam logic [MODE_W-1:0] MODE_MOVE_TO_LOCAL = 3'd6;

	// pool operations
	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

	typedef struct packed {
		logic            go;
		logic [OP_W-1:0] op;
		logic            val;
	} pool_cmd_t;

	typedef struct packed {
		logic done;
		logic full;
		logic bitv;
	} pool_rsp_t;

	// number of bitmap words for a pool
	function automatic int rows_of(int pages);
		return (pages + WORD_W - 1) / WORD_W;
	endfunction

	// word address width for a pool
	function automatic int row_w_of(int pages);
		return (rows_of(pages) > 1) ? $clog2(rows_of(pages)) : 1;
	endfunction

	// position of the lowest set bit, zero when none
	function automatic logic [BIT_W-1:0] first_set(word_t w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i])
				pos = BIT_W'(i);
		end
		return pos;
	endfunction

endpackage

FILE: rtl/core/dpba_pool.sv
// one page pool: bitmap memory, row valid bits, used count and first-free scan
`include "dual_pool_page_bitmap_allocator_core_macros.svh"

module dpba_pool #(
	parameter int PAGES = 64,
	parameter int IDX_W = 6,
	localparam int ROW_W = dpba_pkg::row_w_of(PAGES),
	localparam int CNT_W = $clog2(PAGES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dpba_pkg::pool_cmd_t             cmd,
	input  logic [IDX_W-1:0]                idx,
	output dpba_pkg::pool_rsp_t             rsp,
	output logic [ROW_W+dpba_pkg::BIT_W-1:0] page,
	output logic [CNT_W-1:0]                count
);
	import dpba_pkg::*;

	localparam int ROWS      = rows_of(PAGES);
	localparam int LAST_BITS = PAGES - (ROWS - 1) * WORD_W;
	localparam word_t TAIL_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_BIT  = 2'd1;
	localparam logic [1:0] P_SCAN = 2'd2;

	logic [1:0]       state_q;
	logic [ROW_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic             row_valid_q [ROWS];

	logic [OP_W-1:0]  op_q;
	logic             val_q;
	logic             in_range_q;
	logic [ROW_W-1:0] row_q;
	logic [BIT_W-1:0] bit_q;

	word_t            mem [ROWS];
	word_t            rd_data_s1;
	logic             rd_live_s1;

	logic [31:0]      idx_wide;
	logic             idx_ok;
	logic [ROW_W-1:0] idx_row;
	logic [BIT_W-1:0] idx_bit;
	word_t            word;
	word_t            free;
	logic [BIT_W-1:0] free_pos;
	logic             rd_en;
	logic [ROW_W-1:0] rd_row;
	logic             wr_en;
	logic [ROW_W-1:0] wr_row;
	word_t            wr_data;

	// request page split into word address and bit
	assign idx_wide = 32'(idx);
	assign idx_ok   = idx_wide < 32'(PAGES);
	assign idx_row  = idx_wide[BIT_W +: ROW_W];
	assign idx_bit  = idx_wide[BIT_W-1:0];

	// a row never written reads as all free
	assign word     = rd_live_s1 ? rd_data_s1 : '0;
	assign free     = ~word & ((scan_q == LAST_ROW) ? TAIL_MASK : {WORD_W{1'b1}});
	assign free_pos = first_set(free);
	assign page     = {scan_q, free_pos};
	assign count    = count_q;

	// memory access and response per state
	always_comb begin
		rd_en   = 1'b0;
		rd_row  = '0;
		wr_en   = 1'b0;
		wr_row  = row_q;
		wr_data = word;
		rsp     = '0;
		case (state_q)
			P_IDLE: begin
				if (cmd.go) begin
					rd_en = 1'b1;
					if (cmd.op != OP_FIND && idx_ok)
						rd_row = idx_row;
				end
			end
			P_BIT: begin
				rsp.done = 1'b1;
				rsp.bitv = in_range_q & word[bit_q];
				if (op_q == OP_WRITE && in_range_q) begin
					wr_en          = 1'b1;
					wr_data[bit_q] = val_q;
				end
			end
			P_SCAN: begin
				if (free != '0) begin
					rsp.done = 1'b1;
					wr_en    = 1'b1;
					wr_row   = scan_q;
					wr_data  = word | (word_t'(1) << free_pos);
				end else if (scan_q == LAST_ROW) begin
					rsp.done = 1'b1;
					rsp.full = 1'b1;
				end else begin
					rd_en  = 1'b1;
					rd_row = scan_q + ROW_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// bitmap memory, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_row] <= wr_data;
		if (rd_en) begin
			rd_data_s1 <= mem[rd_row];
			rd_live_s1 <= row_valid_q[rd_row];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (state_q == P_IDLE && cmd.go) begin
			op_q       <= cmd.op;
			val_q      <= cmd.val;
			in_range_q <= idx_ok;
			row_q      <= idx_row;
			bit_q      <= idx_bit;
		end
	end

	// sequencer, used count and row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			scan_q  <= '0;
			count_q <= '0;
			for (int r = 0; r < ROWS; r++)
				row_valid_q[r] <= 1'b0;
		end else begin
			if (wr_en)
				row_valid_q[wr_row] <= 1'b1;
			case (state_q)
				P_IDLE: begin
					if (cmd.go) begin
						scan_q  <= '0;
						state_q <= (cmd.op == OP_FIND) ? P_SCAN : P_BIT;
					end
				end
				P_BIT: begin
					if (op_q == OP_WRITE && in_range_q) begin
						if (word[bit_q] && !val_q)
							count_q <= count_q - CNT_W'(1);
						else if (!word[bit_q] && val_q)
							count_q <= count_q + CNT_W'(1);
					end
					state_q <= P_IDLE;
				end
				P_SCAN: begin
					if (free != '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= P_IDLE;
					end else if (scan_q == LAST_ROW) begin
						state_q <= P_IDLE;
					end else begin
						scan_q <= scan_q + ROW_W'(1);
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	`DPBA_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, 32'(count_q) <= 32'(PAGES), "pool count above size")
	`DPBA_ASSERT_IMP(a_go_when_idle, clk, arst_n, cmd.go, state_q == P_IDLE, "pool command while busy")
	`DPBA_ASSERT_IMP(a_full_no_write, clk, arst_n, rsp.full, !wr_en && count_q == CNT_W'(PAGES), "full but free page left")

endmodule

FILE: rtl/core/dual_pool_page_bitmap_allocator_core.sv
// Dual pool page allocator: local and disk page bitmaps with first-fit allocation.
// Input channel (in_valid/in_ready) carries mode, local_page and disk_page; output
// channel (out_valid/out_ready) returns one result per request: result_page, status,
// local_in_use, disk_in_use and transfer_count after the request.
// One request is worked at a time. Each bitmap sits in a memory of 32-bit words with
// a registered read; every write is a read, modify, write of one word.
// A request passes S_START and then S_WAIT1 until its first phase is done; an unused
// mode goes from S_START straight to S_OUT. Swap, and a move with room in the target
// pool, then pass S_SECOND and S_WAIT2 before S_OUT.
// An allocation scans at most ceil(pages / 32) words of the target pool: 2 for the
// local pool and 8 for the disk pool by default.
// The result is loaded into the output register as the request leaves S_OUT.
// The output register keeps the result while out_ready is low; a new request is
// taken meanwhile and waits in S_OUT until the output register frees.
// Reset clears all counters and marks every page free at once through per-word
// valid bits; requests are taken from the first cycle after reset.
`include "dual_pool_page_bitmap_allocator_core_macros.svh"

module dual_pool_page_bitmap_allocator_core #(
	parameter int LOCAL_PAGES = 64,
	parameter int DISK_PAGES  = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [dpba_pkg::MODE_W-1:0]        mode,
	input  logic [dpba_pkg::LPAGE_W-1:0]       local_page,
	input  logic [dpba_pkg::DPAGE_W-1:0]       disk_page,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [dpba_pkg::RPAGE_W-1:0]       result_page,
	output logic                               status,
	output logic [dpba_pkg::LCNT_OUT_W-1:0]    local_in_use,
	output logic [dpba_pkg::DCNT_OUT_W-1:0]    disk_in_use,
	output logic [dpba_pkg::XFER_W-1:0]        transfer_count
);
	import dpba_pkg::*;

	localparam int LPG_W  = row_w_of(LOCAL_PAGES) + BIT_W;
	localparam int DPG_W  = row_w_of(DISK_PAGES) + BIT_W;
	localparam int LCNT_W = $clog2(LOCAL_PAGES + 1);
	localparam int DCNT_W = $clog2(DISK_PAGES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_START  = 3'd1;
	localparam logic [2:0] S_WAIT1  = 3'd2;
	localparam logic [2:0] S_SECOND = 3'd3;
	localparam logic [2:0] S_WAIT2  = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0]          state_q;
	logic [XFER_W-1:0]   transfers_q;
	logic                out_valid_q;

	logic [MODE_W-1:0]   mode_q;
	logic [LPAGE_W-1:0]  lpage_q;
	logic [DPAGE_W-1:0]  dpage_q;
	logic [RPAGE_W-1:0]  page_q;
	logic                full_q;
	logic                bl_q;
	logic                bd_q;

	logic [RPAGE_W-1:0]    result_page_q;
	logic                  status_q;
	logic [LCNT_OUT_W-1:0] local_in_use_q;
	logic [DCNT_OUT_W-1:0] disk_in_use_q;
	logic [XFER_W-1:0]     transfer_count_q;

	pool_cmd_t           lcmd;
	pool_cmd_t           dcmd;
	pool_rsp_t           lrsp;
	pool_rsp_t           drsp;
	logic [LPG_W-1:0]    lpage_found;
	logic [DPG_W-1:0]    dpage_found;
	logic [LCNT_W-1:0]   lcount;
	logic [DCNT_W-1:0]   dcount;
	logic                in_fire;
	logic                out_load;
	logic                wait1_done;
	logic                wait2_done;

	dpba_pool #(
		.PAGES (LOCAL_PAGES),
		.IDX_W (LPAGE_W)
	) u_local (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd),
		.idx    (lpage_q),
		.rsp    (lrsp),
		.page   (lpage_found),
		.count  (lcount)
	);

	dpba_pool #(
		.PAGES (DISK_PAGES),
		.IDX_W (DPAGE_W)
	) u_disk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.idx    (dpage_q),
		.rsp    (drsp),
		.page   (dpage_found),
		.count  (dcount)
	);

	// handshakes
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// which pool finishes each phase
	assign wait1_done = (mode_q inside {MODE_ALLOC_DISK, MODE_FREE_DISK, MODE_MOVE_TO_DISK})
		? drsp.done : lrsp.done;
	assign wait2_done = (mode_q == MODE_MOVE_TO_LOCAL) ? drsp.done : lrsp.done;

	// pool commands per phase
	always_comb begin
		lcmd = '0;
		dcmd = '0;
		if (state_q == S_START) begin
			case (mode_q)
				MODE_ALLOC_LOCAL, MODE_MOVE_TO_LOCAL: begin
					lcmd.go = 1'b1;
					lcmd.op = OP_FIND;
				end
				MODE_ALLOC_DISK, MODE_MOVE_TO_DISK: begin
					dcmd.go = 1'b1;
					dcmd.op = OP_FIND;
				end
				MODE_FREE_LOCAL: begin
					lcmd.go = 1'b1;
					lcmd.op = OP_WRITE;
				end
				MODE_FREE_DISK: begin
					dcmd.go = 1'b1;
					dcmd.op = OP_WRITE;
				end
				MODE_SWAP: begin
					lcmd.go = 1'b1;
					lcmd.op = OP_READ;
					dcmd.go = 1'b1;
					dcmd.op = OP_READ;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_SECOND) begin
			case (mode_q)
				MODE_SWAP: begin
					lcmd.go  = 1'b1;
					lcmd.op  = OP_WRITE;
					lcmd.val = bd_q;
					dcmd.go  = 1'b1;
					dcmd.op  = OP_WRITE;
					dcmd.val = bl_q;
				end
				MODE_MOVE_TO_DISK: begin
					lcmd.go = 1'b1;
					lcmd.op = OP_WRITE;
				end
				MODE_MOVE_TO_LOCAL: begin
					dcmd.go = 1'b1;
					dcmd.op = OP_WRITE;
				end
				default: begin
				end
			endcase
		end
	end

	// request fields and phase results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q  <= mode;
			lpage_q <= local_page;
			dpage_q <= disk_page;
			page_q  <= '0;
			full_q  <= 1'b0;
		end
		if (state_q == S_WAIT1 && wait1_done) begin
			case (mode_q)
				MODE_ALLOC_LOCAL, MODE_MOVE_TO_LOCAL: begin
					full_q <= lrsp.full;
					page_q <= lrsp.full ? '0 : RPAGE_W'(lpage_found);
				end
				MODE_ALLOC_DISK, MODE_MOVE_TO_DISK: begin
					full_q <= drsp.full;
					page_q <= drsp.full ? '0 : RPAGE_W'(dpage_found);
				end
				MODE_SWAP: begin
					bl_q <= lrsp.bitv;
					bd_q <= drsp.bitv;
				end
				default: begin
				end
			endcase
		end
		if (out_load) begin
			result_page_q    <= page_q;
			status_q         <= full_q;
			local_in_use_q   <= LCNT_OUT_W'(lcount);
			disk_in_use_q    <= DCNT_OUT_W'(dcount);
			transfer_count_q <= transfers_q;
		end
	end

	// request sequencer and transfer counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			transfers_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire)
						state_q <= S_START;
				end
				S_START: begin
					state_q <= (mode_q > MODE_MOVE_TO_LOCAL) ? S_OUT : S_WAIT1;
				end
				S_WAIT1: begin
					if (wait1_done) begin
						case (mode_q)
							MODE_SWAP: begin
								transfers_q <= transfers_q + XFER_W'(2);
								state_q     <= S_SECOND;
							end
							MODE_MOVE_TO_DISK: begin
								if (!drsp.full) begin
									transfers_q <= transfers_q + XFER_W'(1);
									state_q     <= S_SECOND;
								end else begin
									state_q <= S_OUT;
								end
							end
							MODE_MOVE_TO_LOCAL: begin
								if (!lrsp.full) begin
									transfers_q <= transfers_q + XFER_W'(1);
									state_q     <= S_SECOND;
								end else begin
									state_q <= S_OUT;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SECOND: begin
					state_q <= S_WAIT2;
				end
				S_WAIT2: begin
					if (wait2_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output ports
	assign out_valid      = out_valid_q;
	assign result_page    = result_page_q;
	assign status         = status_q;
	assign local_in_use   = local_in_use_q;
	assign disk_in_use    = disk_in_use_q;
	assign transfer_count = transfer_count_q;

	`DPBA_ASSERT_IMP(a_swap_lockstep, clk, arst_n, (state_q == S_WAIT1 || state_q == S_WAIT2) && mode_q == MODE_SWAP, lrsp.done == drsp.done, "swap pools out of step")
	`DPBA_ASSERT_NXT(a_xfer_hold, clk, arst_n, state_q != S_WAIT1, $stable(transfers_q), "transfer count moved outside update")
	`DPBA_ASSERT_IMP(a_full_no_page, clk, arst_n, out_valid_q && status_q, result_page_q == '0, "full status with a page number")

endmodule
